// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and switched off while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/core/dbar_pkg.sv
// ----------------------------------------------------------------------------
// dbar_pkg
// Shared widths, register indexes, reset values and digit helpers for the
// debounced button with accelerating auto repeat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dbar_pkg;

  localparam int unsigned TimeW      = 32;
  localparam int unsigned CfgW       = 16;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned NumDigits  = TimeW / DigitW;
  localparam int unsigned CfgDigits  = CfgW / DigitW;
  localparam int unsigned DigitCntW  = $clog2(NumDigits);
  localparam int unsigned StepCntW   = $clog2(CfgW);
  localparam int unsigned CfgIdxW    = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE  = 3'd0,
    REG_HOLD_THR  = 3'd1,
    REG_INIT_REP  = 3'd2,
    REG_MIN_REP   = 3'd3,
    REG_ACCEL     = 3'd4
  } reg_idx_e;

  localparam logic [CfgW-1:0] DebounceRst = 16'd50;
  localparam logic [CfgW-1:0] HoldThrRst  = 16'd500;
  localparam logic [CfgW-1:0] InitRepRst  = 16'd200;
  localparam logic [CfgW-1:0] MinRepRst   = 16'd50;
  localparam logic [CfgW-1:0] AccelRst    = 16'd2000;

  // Results of one serial pass over the timestamp differences.
  typedef struct packed {
    logic dbc_gt;    // now - change_time > debounce
    logic hold_lt;   // hold time below hold threshold
    logic p_ge_acc;  // progress past hold threshold reached accel time
  } diff_flags_t;

  // One digit of a subtraction; the top bit is the borrow out.
  function automatic logic [DigitW:0] sub_digit(input logic [DigitW-1:0] a,
                                                input logic [DigitW-1:0] b,
                                                input logic              bin);
    sub_digit = {1'b0, a} - {1'b0, b} - {{DigitW{1'b0}}, bin};
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/debounced_button_auto_repeat.sv
// ----------------------------------------------------------------------------
// debounced_button_auto_repeat
// Debounced active-low button with accelerating auto repeat.
// ----------------------------------------------------------------------------
// Input channel: one item per button sample (raw_level_i, now_ms_i), taken
// with in_valid_i / in_ready_o. Output channel: one result item per sample
// (fire_o, held_o, hold_duration_o) on out_valid_o / out_ready_i.
// Config: cfg_we_i writes cfg_data_i into register cfg_idx_i; indexes past
// the accel register are dropped. Write only while the block is idle.
// Flow: one item at a time. The timestamp differences run through a 4-bit
// digit-serial subtractor bank, then a decide step; a repeat check adds a
// compare step. While the repeat interval is still accelerating, a
// bit-serial multiply and then a divide run ahead of that compare.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the following result holds in the sequencer
// until the output register frees up.
// Reset: config returns to 50/500/200/50/2000 ms, the button reads released,
// the change, press and repeat timestamps clear, no result is pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module debounced_button_auto_repeat (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [dbar_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [dbar_pkg::CfgW-1:0]       cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            raw_level_i,
  input  wire logic [dbar_pkg::TimeW-1:0]      now_ms_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 fire_o,
  output logic                                 held_o,
  output logic [dbar_pkg::TimeW-1:0]           hold_duration_o
);

  localparam int unsigned TW = dbar_pkg::TimeW;
  localparam int unsigned CW = dbar_pkg::CfgW;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DIFF   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_ARITH  = 6'b001000,
    S_CMP    = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] deb_q, thr_q, init_q, min_q, acc_q;
  logic          prev_raw_q, stable_q, held_q;
  logic [TW-1:0] change_q, press_q, repeat_q;
  logic [TW-1:0] now_q;
  logic          raw_q;
  logic          res_fire_q, press_evt_q, use_div_q;

  logic          accept;
  logic [TW-1:0] chg_eff;
  logic          diff_done;
  dbar_pkg::diff_flags_t flags;
  logic [TW-1:0] hold_val, drep_val;
  logic [CW-1:0] prog_val;
  logic          md_start, md_done;
  logic [CW-1:0] quot;
  logic          min_gt_init, repeat_path, need_div;
  logic [CW-1:0] interval;
  logic          rep_due;
  logic          out_load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  // A level change restarts the debounce timer right away.
  assign chg_eff     = (raw_level_i != prev_raw_q) ? now_ms_i : change_q;

  assign min_gt_init = (min_q > init_q);
  assign repeat_path = flags.dbc_gt && (raw_q == stable_q) && !stable_q && held_q
                       && !flags.hold_lt;
  assign need_div    = !min_gt_init && !flags.p_ge_acc;
  assign md_start    = (state_q == S_DECIDE) && repeat_path && need_div;
  assign interval    = use_div_q ? (init_q - quot) : min_q;
  assign rep_due     = (|drep_val[TW-1:CW]) || (drep_val[CW-1:0] >= interval);
  assign out_load    = (state_q == S_DONE) && (!out_valid_o || out_ready_i);

  dbar_diff u_diff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .now_i   (now_ms_i),
    .chg_i   (chg_eff),
    .prs_i   (press_q),
    .rep_i   (repeat_q),
    .deb_i   (deb_q),
    .thr_i   (thr_q),
    .acc_i   (acc_q),
    .done_o  (diff_done),
    .flags_o (flags),
    .hold_o  (hold_val),
    .drep_o  (drep_val),
    .prog_o  (prog_val)
  );

  dbar_muldiv u_muldiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (md_start),
    .mcand_i   (init_q - min_q),
    .mplier_i  (prog_val),
    .divisor_i (acc_q),
    .done_o    (md_done),
    .quot_o    (quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_DIFF;
      end
      S_DIFF: begin
        if (diff_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (repeat_path) begin
          state_d = need_div ? S_ARITH : S_CMP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_ARITH: begin
        if (md_done) state_d = S_CMP;
      end
      S_CMP: state_d = S_DONE;
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      deb_q       <= dbar_pkg::DebounceRst;
      thr_q       <= dbar_pkg::HoldThrRst;
      init_q      <= dbar_pkg::InitRepRst;
      min_q       <= dbar_pkg::MinRepRst;
      acc_q       <= dbar_pkg::AccelRst;
      prev_raw_q  <= 1'b1;
      stable_q    <= 1'b1;
      held_q      <= 1'b0;
      change_q    <= '0;
      press_q     <= '0;
      repeat_q    <= '0;
      res_fire_q  <= 1'b0;
      press_evt_q <= 1'b0;
      use_div_q   <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          dbar_pkg::REG_DEBOUNCE: deb_q  <= cfg_data_i;
          dbar_pkg::REG_HOLD_THR: thr_q  <= cfg_data_i;
          dbar_pkg::REG_INIT_REP: init_q <= cfg_data_i;
          dbar_pkg::REG_MIN_REP:  min_q  <= cfg_data_i;
          dbar_pkg::REG_ACCEL:    acc_q  <= cfg_data_i;
          default: ;
        endcase
      end

      if (accept) begin
        change_q    <= chg_eff;
        prev_raw_q  <= raw_level_i;
        res_fire_q  <= 1'b0;
        press_evt_q <= 1'b0;
      end

      if (state_q == S_DECIDE) begin
        use_div_q <= need_div;
        if (flags.dbc_gt && (raw_q != stable_q)) begin
          stable_q <= raw_q;
          if (!raw_q) begin
            press_q     <= now_q;
            repeat_q    <= now_q;
            held_q      <= 1'b1;
            res_fire_q  <= 1'b1;
            press_evt_q <= 1'b1;
          end else begin
            held_q <= 1'b0;
          end
        end
      end

      if (state_q == S_CMP && rep_due) begin
        repeat_q   <= now_q;
        res_fire_q <= 1'b1;
      end

      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q <= now_ms_i;
      raw_q <= raw_level_i;
    end
    if (out_load) begin
      fire_o          <= res_fire_q;
      held_o          <= held_q;
      // A fresh press reads zero hold time.
      hold_duration_o <= (held_q && !press_evt_q) ? hold_val : '0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dbar_diff.sv
// ----------------------------------------------------------------------------
// dbar_diff
// Digit-serial subtractor bank: forms the three timestamp differences and
// their compares against the config limits, one 4-bit digit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dbar_diff (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic [dbar_pkg::TimeW-1:0]         now_i,
  input  wire logic [dbar_pkg::TimeW-1:0]         chg_i,
  input  wire logic [dbar_pkg::TimeW-1:0]         prs_i,
  input  wire logic [dbar_pkg::TimeW-1:0]         rep_i,
  input  wire logic [dbar_pkg::CfgW-1:0]          deb_i,
  input  wire logic [dbar_pkg::CfgW-1:0]          thr_i,
  input  wire logic [dbar_pkg::CfgW-1:0]          acc_i,
  output logic                                    done_o,
  output dbar_pkg::diff_flags_t                   flags_o,
  output logic [dbar_pkg::TimeW-1:0]              hold_o,
  output logic [dbar_pkg::TimeW-1:0]              drep_o,
  output logic [dbar_pkg::CfgW-1:0]               prog_o
);

  localparam int unsigned TW = dbar_pkg::TimeW;
  localparam int unsigned CW = dbar_pkg::CfgW;
  localparam int unsigned DW = dbar_pkg::DigitW;

  logic [TW-1:0] now_sr_q, chg_sr_q, prs_sr_q, rep_sr_q;
  logic [CW-1:0] deb_sr_q, thr_sr_q, acc_sr_q;
  logic [TW-1:0] hold_sr_q, drep_sr_q;
  logic [CW-1:0] prog_sr_q;
  logic b_chg_q, b_deb_q, b_hold_q, b_thr_q, b_acc_q, b_rep_q;
  logic [dbar_pkg::DigitCntW-1:0] cnt_q;
  logic busy_q;

  logic [DW:0] r_chg, r_deb, r_hold, r_thr, r_acc, r_rep;

  // Chain the compares behind the differences within the same digit.
  assign r_chg  = dbar_pkg::sub_digit(now_sr_q[DW-1:0], chg_sr_q[DW-1:0], b_chg_q);
  assign r_deb  = dbar_pkg::sub_digit(deb_sr_q[DW-1:0], r_chg[DW-1:0], b_deb_q);
  assign r_hold = dbar_pkg::sub_digit(now_sr_q[DW-1:0], prs_sr_q[DW-1:0], b_hold_q);
  assign r_thr  = dbar_pkg::sub_digit(r_hold[DW-1:0], thr_sr_q[DW-1:0], b_thr_q);
  assign r_acc  = dbar_pkg::sub_digit(r_thr[DW-1:0], acc_sr_q[DW-1:0], b_acc_q);
  assign r_rep  = dbar_pkg::sub_digit(now_sr_q[DW-1:0], rep_sr_q[DW-1:0], b_rep_q);

  assign done_o = busy_q && (cnt_q == dbar_pkg::DigitCntW'(dbar_pkg::NumDigits - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cnt_q    <= '0;
      b_chg_q  <= 1'b0;
      b_deb_q  <= 1'b0;
      b_hold_q <= 1'b0;
      b_thr_q  <= 1'b0;
      b_acc_q  <= 1'b0;
      b_rep_q  <= 1'b0;
    end else if (start_i) begin
      busy_q   <= 1'b1;
      cnt_q    <= '0;
      b_chg_q  <= 1'b0;
      b_deb_q  <= 1'b0;
      b_hold_q <= 1'b0;
      b_thr_q  <= 1'b0;
      b_acc_q  <= 1'b0;
      b_rep_q  <= 1'b0;
    end else if (busy_q) begin
      cnt_q    <= cnt_q + 1'b1;
      if (done_o) begin
        busy_q <= 1'b0;
      end
      b_chg_q  <= r_chg[DW];
      b_deb_q  <= r_deb[DW];
      b_hold_q <= r_hold[DW];
      b_thr_q  <= r_thr[DW];
      b_acc_q  <= r_acc[DW];
      b_rep_q  <= r_rep[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      now_sr_q <= now_i;
      chg_sr_q <= chg_i;
      prs_sr_q <= prs_i;
      rep_sr_q <= rep_i;
      deb_sr_q <= deb_i;
      thr_sr_q <= thr_i;
      acc_sr_q <= acc_i;
    end else if (busy_q) begin
      now_sr_q  <= {{DW{1'b0}}, now_sr_q[TW-1:DW]};
      chg_sr_q  <= {{DW{1'b0}}, chg_sr_q[TW-1:DW]};
      prs_sr_q  <= {{DW{1'b0}}, prs_sr_q[TW-1:DW]};
      rep_sr_q  <= {{DW{1'b0}}, rep_sr_q[TW-1:DW]};
      deb_sr_q  <= {{DW{1'b0}}, deb_sr_q[CW-1:DW]};
      thr_sr_q  <= {{DW{1'b0}}, thr_sr_q[CW-1:DW]};
      acc_sr_q  <= {{DW{1'b0}}, acc_sr_q[CW-1:DW]};
      hold_sr_q <= {r_hold[DW-1:0], hold_sr_q[TW-1:DW]};
      drep_sr_q <= {r_rep[DW-1:0], drep_sr_q[TW-1:DW]};
      // Keep only the low half of the progress value.
      if (cnt_q < dbar_pkg::DigitCntW'(dbar_pkg::CfgDigits)) begin
        prog_sr_q <= {r_thr[DW-1:0], prog_sr_q[CW-1:DW]};
      end
    end
  end

  assign flags_o.dbc_gt   = b_deb_q;
  assign flags_o.hold_lt  = b_thr_q;
  assign flags_o.p_ge_acc = !b_acc_q;
  assign hold_o           = hold_sr_q;
  assign drep_o           = drep_sr_q;
  assign prog_o           = prog_sr_q;

endmodule

`default_nettype wire

// File: rtl/core/dbar_muldiv.sv
// ----------------------------------------------------------------------------
// dbar_muldiv
// Serial shift-add multiply followed by a restoring divide on the same
// register pair: quotient = floor(mcand * mplier / divisor), one bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dbar_muldiv (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [dbar_pkg::CfgW-1:0]   mcand_i,
  input  wire logic [dbar_pkg::CfgW-1:0]   mplier_i,
  input  wire logic [dbar_pkg::CfgW-1:0]   divisor_i,
  output logic                             done_o,
  output logic [dbar_pkg::CfgW-1:0]        quot_o
);

  localparam int unsigned CW = dbar_pkg::CfgW;

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_e;

  md_state_e state_q, state_d;
  logic [dbar_pkg::StepCntW-1:0] cnt_q;
  logic [CW-1:0] hi_q, lo_q, mcand_q, div_q;
  logic [CW:0]   mul_sum, div_r2, div_rem;
  logic          div_ge;
  logic          last_step;

  assign last_step = (cnt_q == dbar_pkg::StepCntW'(CW - 1));
  assign mul_sum   = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);
  assign div_r2    = {hi_q, lo_q[CW-1]};
  assign div_ge    = (div_r2 >= {1'b0, div_q});
  assign div_rem   = div_ge ? (div_r2 - {1'b0, div_q}) : div_r2;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MD_IDLE: begin
        if (start_i) state_d = MD_MUL;
      end
      MD_MUL: begin
        if (last_step) state_d = MD_DIV;
      end
      MD_DIV: begin
        if (last_step) state_d = MD_IDLE;
      end
      default: state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == MD_IDLE || last_step) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // The high half of the product stays below the divisor, so it seeds the
  // remainder directly.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          hi_q    <= '0;
          lo_q    <= mplier_i;
          mcand_q <= mcand_i;
          div_q   <= divisor_i;
        end
      end
      MD_MUL: begin
        hi_q <= mul_sum[CW:1];
        lo_q <= {mul_sum[0], lo_q[CW-1:1]};
      end
      MD_DIV: begin
        hi_q <= div_rem[CW-1:0];
        lo_q <= {lo_q[CW-2:0], div_ge};
      end
      default: ;
    endcase
  end

  assign done_o = (state_q == MD_DIV) && last_step;
  assign quot_o = lo_q;

endmodule

`default_nettype wire

// File: rtl/core/dbar_checker.sv
// ----------------------------------------------------------------------------
// dbar_checker
// Port-level checks for the debounced button block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dbar_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_ready_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_ready_i,
  input wire logic                            fire_o,
  input wire logic                            held_o,
  input wire logic [dbar_pkg::TimeW-1:0]      hold_duration_o
);

  // A fire only ever happens with the button held.
  `ASSERT_IMPL(a_fire_held, clk_i, rst_ni, out_valid_o && fire_o, held_o)
  // Hold time reads zero once released.
  `ASSERT_IMPL(a_idle_dur, clk_i, rst_ni, out_valid_o && !held_o, hold_duration_o == '0)
  // One item in flight: ready drops right after an accept.
  `ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // Hold a stalled result.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
               out_valid_o && $stable(fire_o) && $stable(held_o)
               && $stable(hold_duration_o))

endmodule

bind debounced_button_auto_repeat dbar_checker u_dbar_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .fire_o          (fire_o),
  .held_o          (held_o),
  .hold_duration_o (hold_duration_o)
);

`default_nettype wire
